// ===== rtl/tvot_pkg.sv =====
package tvot_pkg;

	localparam int unsigned IN_VALUE_W  = 16;
	localparam int unsigned OUT_VALUE_W = 16;
	localparam int unsigned COL_W       = 4;
	localparam int unsigned S_TDATA_W   = 16;
	localparam int unsigned M_TDATA_W   = 24;
	localparam int unsigned M_TUSER_W   = 2;

	typedef enum logic [2:0] {
		ST_LOAD_RD,
		ST_LOAD_WAIT,
		ST_START,
		ST_EMIT_RD,
		ST_EMIT_CHK,
		ST_COL_END,
		ST_NONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_scan;
		logic scan_start;
		logic scan_inc;
		logic col_inc;
		logic take;
		logic push_held;
		logic push_end;
		logic push_none;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic root_reach;
		logic match;
		logic held_valid;
		logic out_free;
		logic scan_last;
		logic col_last;
	} status_t;

endpackage

// ===== rtl/tree_vertical_order_traversal.sv =====
// Vertical order traversal of a binary tree given in level-order array layout. Each input beat
// is one slot (tdata = value, tuser = empty flag, tlast = final slot); each slot passes through
// a read state and then a wait state that takes the beat, because the parent's reachable flag
// and column come from a registered memory read. After the final slot the block scans all
// stored slots once per column, left to right, reading and then checking each slot and closing
// each column with a column-end step; the output side can stall the scan. An empty root yields
// one result beat flagged no_nodes. Slots beyond MAX_SLOTS are dropped. No clearing pass
// follows reset.
module tree_vertical_order_traversal #(
	parameter int unsigned MAX_SLOTS  = 64,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tvot_pkg::S_TDATA_W-1:0]     s_tdata,  // node_value
	input  logic                               s_tuser,  // is_empty
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tvot_pkg::M_TDATA_W-1:0]     m_tdata,  // out_value, column, zero pad
	output logic [tvot_pkg::M_TUSER_W-1:0]     m_tuser,  // column_end, no_nodes
	output logic                               m_tlast
);

	tvot_pkg::cmd_t    cmd;
	tvot_pkg::status_t st;

	tvot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.st       (st),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	tvot_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/tvot_ctrl.sv =====
module tvot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tlast,
	input  tvot_pkg::status_t st,
	output tvot_pkg::cmd_t    cmd,
	output logic              s_tready
);

	tvot_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvot_pkg::ST_LOAD_RD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tvot_pkg::ST_LOAD_RD: begin
				state_d = tvot_pkg::ST_LOAD_WAIT;
			end
			tvot_pkg::ST_LOAD_WAIT: begin
				if (s_tvalid) begin
					state_d = s_tlast ? tvot_pkg::ST_START : tvot_pkg::ST_LOAD_RD;
				end
			end
			tvot_pkg::ST_START: begin
				state_d = st.root_reach ? tvot_pkg::ST_EMIT_RD : tvot_pkg::ST_NONE;
			end
			tvot_pkg::ST_EMIT_RD: begin
				state_d = tvot_pkg::ST_EMIT_CHK;
			end
			tvot_pkg::ST_EMIT_CHK: begin
				if (!(st.match && st.held_valid && !st.out_free)) begin
					state_d = st.scan_last ? tvot_pkg::ST_COL_END : tvot_pkg::ST_EMIT_RD;
				end
			end
			tvot_pkg::ST_COL_END: begin
				if (!(st.held_valid && !st.out_free)) begin
					state_d = st.col_last ? tvot_pkg::ST_LOAD_RD : tvot_pkg::ST_EMIT_RD;
				end
			end
			tvot_pkg::ST_NONE: begin
				if (st.out_free) begin
					state_d = tvot_pkg::ST_LOAD_RD;
				end
			end
			default: state_d = tvot_pkg::ST_LOAD_RD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			tvot_pkg::ST_LOAD_RD: begin
			end
			tvot_pkg::ST_LOAD_WAIT: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			tvot_pkg::ST_START: begin
				cmd.scan_start = st.root_reach;
			end
			tvot_pkg::ST_EMIT_RD: begin
				cmd.rd_scan = 1'b1;
			end
			tvot_pkg::ST_EMIT_CHK: begin
				cmd.rd_scan = 1'b1;
				if (!(st.match && st.held_valid && !st.out_free)) begin
					cmd.take      = st.match;
					cmd.push_held = st.match && st.held_valid;
					cmd.scan_inc  = !st.scan_last;
				end
			end
			tvot_pkg::ST_COL_END: begin
				if (!(st.held_valid && !st.out_free)) begin
					cmd.push_end = st.held_valid;
					cmd.finish   = st.col_last;
					cmd.col_inc  = !st.col_last;
				end
			end
			tvot_pkg::ST_NONE: begin
				cmd.push_none = st.out_free;
				cmd.finish    = st.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/tvot_dp.sv =====
module tvot_dp #(
	parameter int unsigned MAX_SLOTS  = 64,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tvot_pkg::cmd_t                       cmd,
	output tvot_pkg::status_t                    st,
	input  logic [tvot_pkg::S_TDATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [tvot_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [tvot_pkg::M_TUSER_W-1:0]       m_tuser,
	output logic                                 m_tlast
);

	localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CL = tvot_pkg::COL_W;
	localparam int unsigned EW = VALUE_BITS + CL + 1;

	logic [EW-1:0] mem [MAX_SLOTS];
	logic [EW-1:0] rd_q;

	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        scan_q;
	logic signed [CL-1:0] cur_col_q, left_q, right_q;
	logic                 root_q;
	logic                 held_v_q;
	logic [VALUE_BITS-1:0] held_val_q;
	logic signed [CL-1:0] held_col_q;
	logic                 out_v_q;

	logic [CW-1:0]        cnt_m1;
	logic [AW-1:0]        parent_addr, wr_addr, rd_addr;
	logic                 rd_reach;
	logic signed [CL-1:0] rd_col;
	logic [VALUE_BITS-1:0] rd_val;
	logic                 first_slot, has_room, ld_reach, out_free;
	logic signed [CL-1:0] ld_col;
	logic [VALUE_BITS+tvot_pkg::IN_VALUE_W-1:0]  ext_in;
	logic [VALUE_BITS+tvot_pkg::OUT_VALUE_W-1:0] ext_held;
	logic [VALUE_BITS-1:0] ld_val;

	assign cnt_m1      = cnt_q - CW'(1);
	assign parent_addr = AW'(cnt_m1 >> 1);
	assign wr_addr     = AW'(cnt_q);
	assign rd_addr     = cmd.rd_scan ? scan_q : parent_addr;

	assign rd_reach = rd_q[EW-1];
	assign rd_col   = signed'(rd_q[EW-2 -: CL]);
	assign rd_val   = rd_q[VALUE_BITS-1:0];

	assign first_slot = (cnt_q == '0);
	assign has_room   = (cnt_q < CW'(MAX_SLOTS));
	assign ld_reach   = !s_tuser && (first_slot || rd_reach);
	assign ld_col     = first_slot ? '0 :
		(cnt_q[0] ? rd_col - CL'(1) : rd_col + CL'(1));
	assign ext_in     = {{VALUE_BITS{1'b0}}, s_tdata[tvot_pkg::IN_VALUE_W-1:0]};
	assign ld_val     = ext_in[VALUE_BITS-1:0];
	assign ext_held   = {{tvot_pkg::OUT_VALUE_W{1'b0}}, held_val_q};
	assign out_free   = !out_v_q || m_tready;

	assign st.root_reach = root_q;
	assign st.match      = rd_reach && (rd_col == cur_col_q);
	assign st.held_valid = held_v_q;
	assign st.out_free   = out_free;
	assign st.scan_last  = (CW'(scan_q) == cnt_m1);
	assign st.col_last   = (cur_col_q == right_q);

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[wr_addr] <= {ld_reach, ld_col, ld_val};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			left_q    <= '0;
			right_q   <= '0;
			root_q    <= 1'b0;
			scan_q    <= '0;
			cur_col_q <= '0;
		end else begin
			if (cmd.finish) begin
				cnt_q   <= '0;
				left_q  <= '0;
				right_q <= '0;
				root_q  <= 1'b0;
			end else if (cmd.load && has_room) begin
				cnt_q <= cnt_q + CW'(1);
				if (first_slot) begin
					root_q <= ld_reach;
				end
				if (ld_reach && (ld_col < left_q)) begin
					left_q <= ld_col;
				end
				if (ld_reach && (ld_col > right_q)) begin
					right_q <= ld_col;
				end
			end
			if (cmd.scan_start) begin
				scan_q    <= '0;
				cur_col_q <= left_q;
			end else if (cmd.col_inc) begin
				scan_q    <= '0;
				cur_col_q <= cur_col_q + CL'(1);
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (cmd.take) begin
			held_v_q <= 1'b1;
		end else if (cmd.push_end) begin
			held_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			held_val_q <= rd_val;
			held_col_q <= rd_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.push_held || cmd.push_end || cmd.push_none) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_none) begin
			m_tdata <= '0;
			m_tuser <= 2'b10;
			m_tlast <= 1'b1;
		end else if (cmd.push_held || cmd.push_end) begin
			m_tdata <= {{(tvot_pkg::M_TDATA_W - tvot_pkg::OUT_VALUE_W - CL){1'b0}},
				held_col_q, ext_held[tvot_pkg::OUT_VALUE_W-1:0]};
			m_tuser <= {1'b0, cmd.push_end};
			m_tlast <= cmd.push_end && (cur_col_q == right_q);
		end
	end

	assign m_tvalid = out_v_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_held || cmd.push_end || cmd.push_none) |-> out_free)
		else $error("result pushed into a full output register");

	a_take_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (st.match && cmd.rd_scan))
		else $error("held entry taken without a column match");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SLOTS))
		else $error("slot count beyond capacity");

	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cnt_q == '0 && !root_q))
		else $error("tree state not cleared after traversal");

	a_no_load_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.rd_scan || held_v_q))
		else $error("slot loaded during emission");

endmodule

// ===== sim/tb_top.sv =====
localparam int TREE_SLOTS = 64;

typedef struct packed {
	logic [tvot_pkg::OUT_VALUE_W-1:0] value;
	logic [tvot_pkg::COL_W-1:0]       column;
	logic                             col_end;
	logic                             run_end;
	logic                             no_nodes;
} node_beat_t;

class vertical_order_board;
	logic [tvot_pkg::IN_VALUE_W-1:0] slot_value [TREE_SLOTS];
	bit                              slot_reach [TREE_SLOTS];
	int                              slot_col   [TREE_SLOTS];
	int unsigned                     loaded;
	int                              leftmost;
	int                              rightmost;
	node_beat_t                      nodes_due [$];
	int                              errors;

	function new();
		errors = 0;
		clear_tree();
	endfunction

	function void clear_tree();
		foreach (slot_reach[i]) begin
			slot_reach[i] = 1'b0;
			slot_col[i]   = 0;
		end
		loaded    = 0;
		leftmost  = 0;
		rightmost = 0;
	endfunction

	task report(input string msg);
		$display("error at %0t: %s", $time, msg);
		errors++;
	endtask

	function void emit_tree();
		node_beat_t b;
		node_beat_t run [$];
		int first;
		if (!slot_reach[0]) begin
			b = '0;
			b.run_end  = 1'b1;
			b.no_nodes = 1'b1;
			nodes_due.push_back(b);
			return;
		end
		for (int c = leftmost; c <= rightmost; c++) begin
			first = run.size();
			for (int i = 0; i < loaded; i++) begin
				if (slot_reach[i] && slot_col[i] == c) begin
					b = '0;
					b.value  = slot_value[i][tvot_pkg::OUT_VALUE_W-1:0];
					b.column = c[tvot_pkg::COL_W-1:0];
					run.push_back(b);
				end
			end
			if (run.size() > first) begin
				b = run[run.size()-1];
				b.col_end = 1'b1;
				run[run.size()-1] = b;
			end
		end
		b = run[run.size()-1];
		b.run_end = 1'b1;
		run[run.size()-1] = b;
		foreach (run[k])
			nodes_due.push_back(run[k]);
	endfunction

	function void take_slot(input logic [15:0] value, input bit empty, input bit last);
		int idx;
		int parent;
		int c;
		bit r;
		if (loaded < TREE_SLOTS) begin
			idx = loaded;
			c   = 0;
			if (idx == 0) begin
				r = !empty;
			end else begin
				parent = (idx - 1) / 2;
				r = !empty && slot_reach[parent];
				c = slot_col[parent] + ((idx % 2) ? -1 : 1);
			end
			slot_value[idx] = value;
			slot_col[idx]   = c;
			slot_reach[idx] = r;
			if (r) begin
				if (c < leftmost)
					leftmost = c;
				if (c > rightmost)
					rightmost = c;
			end
			loaded++;
		end
		if (last) begin
			emit_tree();
			clear_tree();
		end
	endfunction

	task check_node(input logic [tvot_pkg::M_TDATA_W-1:0] tdata,
			input logic [tvot_pkg::M_TUSER_W-1:0] tuser, input logic tlast);
		node_beat_t e;
		if (nodes_due.size() == 0) begin
			report($sformatf("unexpected beat tdata %h tuser %b tlast %b", tdata, tuser, tlast));
			return;
		end
		e = nodes_due.pop_front();
		if (tdata[15:0] !== e.value)
			report($sformatf("out_value %h, want %h", tdata[15:0], e.value));
		if (tdata[19:16] !== e.column)
			report($sformatf("column %0d, want %0d", $signed(tdata[19:16]), $signed(e.column)));
		if (tdata[23:20] !== 4'b0)
			report($sformatf("tdata pad %h not zero", tdata[23:20]));
		if (tuser[0] !== e.col_end)
			report($sformatf("column_end %b, want %b", tuser[0], e.col_end));
		if (tuser[1] !== e.no_nodes)
			report($sformatf("no_nodes %b, want %b", tuser[1], e.no_nodes));
		if (tlast !== e.run_end)
			report($sformatf("run_end %b, want %b", tlast, e.run_end));
	endtask
endclass

module tb_top;
	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [tvot_pkg::S_TDATA_W-1:0]   s_tdata;
	logic                             s_tuser;
	logic                             s_tlast;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [tvot_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [tvot_pkg::M_TUSER_W-1:0]   m_tuser;
	logic                             m_tlast;

	vertical_order_board board = new();
	int slots_sent;
	int quiet_out;
	int stall_out;

	tree_vertical_order_traversal u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	// called at a falling edge, returns at a falling edge after the beat is taken
	task automatic send_slot(input logic [15:0] value, input bit empty, input bit last,
			input bit quiet);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= empty;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		board.take_slot(value, empty, last);
		slots_sent++;
		@(negedge clk);
	endtask

	task automatic send_tree(input int slots, input int empty_pct, input bit quiet);
		for (int i = 0; i < slots; i++) begin
			send_slot(16'($urandom), $urandom_range(99) < empty_pct, i == slots - 1, quiet);
		end
	endtask

	task automatic send_directed();
		// lone root with value 7fff
		send_slot(16'h7fff, 1'b0, 1'b1, 1'b0);
		// empty root alone, then empty root with live children
		send_slot(16'h0000, 1'b1, 1'b1, 1'b0);
		send_slot(16'h1111, 1'b1, 1'b0, 1'b0);
		send_slot(16'h2222, 1'b0, 1'b0, 1'b0);
		send_slot(16'h3333, 1'b0, 1'b1, 1'b0);
		// mixed tree, children of an empty slot stay unreachable
		send_slot(16'h8000, 1'b0, 1'b0, 1'b1);
		send_slot(16'h0001, 1'b0, 1'b0, 1'b1);
		send_slot(16'hffff, 1'b1, 1'b0, 1'b1);
		send_slot(16'hffff, 1'b0, 1'b0, 1'b1);
		send_slot(16'h1234, 1'b0, 1'b0, 1'b1);
		send_slot(16'h5555, 1'b0, 1'b0, 1'b1);
		send_slot(16'haaaa, 1'b0, 1'b1, 1'b1);
		// final slot is a null slot
		send_slot(16'h00ff, 1'b0, 1'b0, 1'b0);
		send_slot(16'hff00, 1'b0, 1'b0, 1'b0);
		send_slot(16'h7f7f, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic send_random();
		int r;
		int slots;
		int empty_pct;
		while (slots_sent < 270) begin
			r = $urandom_range(99);
			if (r < 70)
				slots = $urandom_range(15, 1);
			else if (r < 88)
				slots = $urandom_range(40, 16);
			else if (r < 96)
				slots = TREE_SLOTS;
			else
				slots = $urandom_range(TREE_SLOTS + 8, TREE_SLOTS + 1);
			empty_pct = (slots >= 40) ? $urandom_range(8) : $urandom_range(40);
			send_tree(slots, empty_pct, $urandom_range(99) < 20);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		slots_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_directed();
		send_random();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (board.nodes_due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.nodes_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		m_tready  = 1'b0;
		quiet_out = 0;
		stall_out = 0;
		forever begin
			@(negedge clk);
			if (quiet_out > 0) begin
				quiet_out--;
				m_tready <= 1'b1;
			end else if (stall_out > 0) begin
				stall_out--;
				m_tready <= 1'b0;
			end else if ($urandom_range(99) < 2) begin
				quiet_out = $urandom_range(300, 100);
				m_tready <= 1'b1;
			end else begin
				stall_out = pick_gap();
				m_tready <= (stall_out == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_node(m_tdata, m_tuser, m_tlast);
	end

	initial begin
		#(20 * 800000);
		$display("end of test: mismatches");
		$finish;
	end
endmodule
